[rtl/pvbr_pkg.sv]
// Package for the phase vocoder bin resynthesis block: sizes, codes, tables.
// Used by every module under rtl except pvbr_ram; depends on nothing.
`default_nettype none
package pvbr_pkg;
  localparam int unsigned FftPoints   = 1024;
  localparam int unsigned HalfPoints  = FftPoints / 2;
  localparam int unsigned Depth       = HalfPoints + 1;
  localparam int unsigned AddrW       = $clog2(Depth);
  localparam int unsigned BinW        = 10;
  localparam int unsigned MagW        = 24;
  localparam int unsigned FreqW       = 25;
  localparam int unsigned OutW        = 25;
  localparam int unsigned PhaseW      = 32;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned StepW       = 5;
  localparam int unsigned XW          = 36;   // CORDIC work width, 8 fraction bits
  localparam int unsigned ZW          = 33;
  localparam int unsigned DivW        = 24;   // quotient bits of the source-bin divide
  localparam int unsigned OutLimit    = 16777215;
  localparam logic [29:0] InvGainQ30  = 30'd652032874;

  localparam logic [CfgIdxW-1:0] RegPitch   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFormant = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHop     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFloor   = 2'd3;

  typedef struct packed {
    logic mem_rd;      // read both memories at the captured bin / source bin
    logic ld_calc;     // load: phase increment product, one hop half a cycle
    logic ld_write;    // load: write magnitude and phase
    logic div_start;
    logic div_step;
    logic cordic_init;
    logic cordic_step;
    logic out_load;
  } pvbr_cmd_t;

  typedef struct packed {
    logic kind;
    logic bin_ok;
    logic div_needed;
    logic div_last;
    logic cordic_last;
    logic out_busy;
    logic mul_last;
    logic clearing;
  } pvbr_sts_t;

  function automatic logic [PhaseW-1:0] atan_turns(input logic [StepW-1:0] i);
    logic [PhaseW-1:0] t;
    case (i)
      5'd0:  t = 32'h20000000; 5'd1:  t = 32'h12E4051D; 5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4; 5'd4:  t = 32'h028B0D43; 5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E; 5'd7:  t = 32'h00517C55; 5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2E; 5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2F9;
      5'd15: t = 32'h0000517C; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A2F; 5'd19: t = 32'h00000517; 5'd20: t = 32'h0000028B;
      5'd21: t = 32'h00000145; 5'd22: t = 32'h000000A2; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000028; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005; 5'd28: t = 32'h00000002; 5'd29: t = 32'h00000001;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

[rtl/phase_vocoder_bin_resynthesis_unit.sv]
// Channel | dir | tdata (low bit up)                         | tuser
// s_axis  | in  | bin[9:0] magnitude[33:10] frequency[58:34] | kind
// m_axis  | out | out_bin[9:0] real[34:10] imag[59:35]       | has_mirror
// Load item, from accept to the next accept: decode, two multiply halves, write, idle.
// Synthesize: decide, the 24-step source-bin divide (skipped in bypass, with a zero formant ratio
// or an out-of-range bin), read, init, 30 CORDIC steps, output.
// Reset starts a pass over all 513 phase-store entries that zeroes them; tready stays low until it ends.
// One item at a time; a held result stalls the next synthesize in its output state.
`default_nettype none
module phase_vocoder_bin_resynthesis_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // bin, magnitude, frequency
  input  wire logic        s_axis_tuser,   // kind
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [63:0] m_axis_tdata,   // out_bin, real_part, imag_part
  output      logic        m_axis_tuser    // has_mirror
);
  import pvbr_pkg::*;

  pvbr_cmd_t cmd;
  pvbr_sts_t sts;
  logic fire;
  logic [BinW-1:0] ob;
  logic signed [OutW-1:0] ore, oim;

  assign fire = s_axis_tvalid && s_axis_tready;

  pvbr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(fire), .in_ready_o(s_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  pvbr_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_kind_i(s_axis_tuser), .in_bin_i(s_axis_tdata[9:0]),
    .in_mag_i(s_axis_tdata[33:10]), .in_freq_i(s_axis_tdata[58:34]),
    .cmd_i(cmd), .sts_o(sts),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_bin_o(ob), .out_re_o(ore), .out_im_o(oim), .out_mirror_o(m_axis_tuser)
  );

  assign m_axis_tdata = {4'd0, oim, ore, ob};
endmodule
`default_nettype wire

[rtl/pvbr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Stand-alone; no package use.
`default_nettype none
module pvbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

[rtl/pvbr_ctrl.sv]
// Sequencer for load and synthesize items of the bin resynthesis block.
// Depends on pvbr_pkg for command and status structs.
`default_nettype none
module pvbr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_fire_i,
  output      logic                in_ready_o,
  input  wire pvbr_pkg::pvbr_sts_t sts_i,
  output      pvbr_pkg::pvbr_cmd_t cmd_o
);
  import pvbr_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLdMul = 3'd1;
  localparam logic [2:0] StLdWr  = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StInit  = 3'd5;
  localparam logic [2:0] StCord  = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // hold off items while the phase store is being zeroed
  assign in_ready_o = (state_q == StIdle) && !sts_i.clearing;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_fire_i) state_d = StDiv;
      end
      StDiv: begin
        // first cycle after accept: decide the path (load: read memories); divide steps run here too
        if (!sts_i.kind) begin
          cmd_o.mem_rd = 1'b1;
          state_d = sts_i.bin_ok ? StLdMul : StIdle;
        end else if (sts_i.div_needed) begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_last) state_d = StRead;
        end else begin
          state_d = StRead;
        end
      end
      StLdMul: begin
        cmd_o.ld_calc = 1'b1;
        if (sts_i.mul_last) state_d = StLdWr;
      end
      StLdWr: begin
        cmd_o.ld_write = 1'b1;
        state_d = StIdle;
      end
      StRead: begin
        cmd_o.mem_rd = 1'b1;
        state_d = StInit;
      end
      StInit: begin
        cmd_o.cordic_init = 1'b1;
        state_d = StCord;
      end
      StCord: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_last) state_d = StOut;
      end
      StOut: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    cmd_o.div_start = in_fire_i;
  end

`ifndef NO_ASSERTIONS
  a_out_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy) else $error("output overwrite");
  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |-> state_q == StIdle) else $error("accept while busy");
  a_write_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_write |-> $past(cmd_o.ld_calc)) else $error("write without product");
`endif
endmodule
`default_nettype wire

[rtl/pvbr_datapath.sv]
// Datapath: registers, memories, phase product, source-bin divider, CORDIC, output.
// Depends on pvbr_pkg and pvbr_ram.
`default_nettype none
module pvbr_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pvbr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [pvbr_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_kind_i,
  input  wire logic [pvbr_pkg::BinW-1:0]     in_bin_i,
  input  wire logic [pvbr_pkg::MagW-1:0]     in_mag_i,
  input  wire logic signed [pvbr_pkg::FreqW-1:0] in_freq_i,
  input  wire pvbr_pkg::pvbr_cmd_t           cmd_i,
  output      pvbr_pkg::pvbr_sts_t           sts_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [pvbr_pkg::BinW-1:0]     out_bin_o,
  output      logic signed [pvbr_pkg::OutW-1:0] out_re_o,
  output      logic signed [pvbr_pkg::OutW-1:0] out_im_o,
  output      logic                          out_mirror_o
);
  import pvbr_pkg::*;

  logic [15:0] pitch_q, formant_q;
  logic [31:0] hop_q;
  logic [MagW-1:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q   <= 16'd4096;
      formant_q <= 16'd4096;
      hop_q     <= 32'd22906;
      floor_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPitch:   pitch_q   <= cfg_data_i[15:0];
        RegFormant: formant_q <= cfg_data_i[15:0];
        RegHop:     hop_q     <= cfg_data_i;
        RegFloor:   floor_q   <= cfg_data_i[MagW-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic            kind_q;
  logic [BinW-1:0] bin_q;
  logic [MagW-1:0] mag_q;
  logic signed [FreqW-1:0] freq_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      kind_q <= in_kind_i;
      bin_q  <= in_bin_i;
      mag_q  <= in_mag_i;
      freq_q <= in_freq_i;
    end
  end
  logic bin_ok;
  assign bin_ok = (bin_q <= BinW'(HalfPoints));

  // source bin: restoring divide of (bin*8192 + f) by 2f, one bit a cycle
  logic [DivW-1:0]  num_q;     // shifting dividend / quotient
  logic [17:0]      rem_q;
  logic [StepW-1:0] dcnt_q;
  logic             bypass, fzero;
  logic [17:0]      rem_sh, rem_sub;
  logic [16:0]      den;
  assign bypass = (formant_q >= 16'd4092) && (formant_q <= 16'd4100);
  assign fzero  = (formant_q == 16'd0);
  assign den    = {formant_q, 1'b0};
  assign rem_sh = {rem_q[16:0], num_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q  <= {1'b0, in_bin_i, 13'd0} + {8'd0, formant_q};
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!rem_sub[17]) begin
        rem_q <= rem_sub;
        num_q <= {num_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[DivW-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q + StepW'(1);
    end
  end

  logic src_ok;
  logic [AddrW-1:0] src_addr;
  always_comb begin
    if (bypass) begin
      src_ok   = 1'b1;
      src_addr = bin_q;
    end else begin
      src_ok   = !fzero && (num_q <= DivW'(HalfPoints));
      src_addr = num_q[AddrW-1:0];
    end
  end

  // memories
  logic [MagW-1:0]   mag_rd;
  logic [PhaseW-1:0] ph_rd;
  logic              ld_we;
  logic [PhaseW-1:0] ph_new;
  logic [AddrW-1:0]  mag_raddr;
  assign mag_raddr = kind_q ? src_addr : bin_q[AddrW-1:0];

  pvbr_ram #(.Width(MagW), .Depth(Depth)) u_mag (
    .clk_i, .we_i(ld_we), .waddr_i(bin_q[AddrW-1:0]), .wdata_i(mag_q),
    .re_i(cmd_i.mem_rd), .raddr_i(mag_raddr), .rdata_o(mag_rd)
  );

  // phase store: zeroed by one pass over all entries after reset
  logic              clr_busy_q;
  logic [AddrW-1:0]  clr_addr_q;
  logic              ph_we;
  logic [AddrW-1:0]  ph_waddr;
  logic [PhaseW-1:0] ph_wdata;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) clr_busy_q <= 1'b0;
    end
  end
  assign ph_we    = ld_we || clr_busy_q;
  assign ph_waddr = clr_busy_q ? clr_addr_q : bin_q[AddrW-1:0];
  assign ph_wdata = clr_busy_q ? '0 : ph_new;

  pvbr_ram #(.Width(PhaseW), .Depth(Depth)) u_phase (
    .clk_i, .we_i(ph_we), .waddr_i(ph_waddr), .wdata_i(ph_wdata),
    .re_i(cmd_i.mem_rd), .raddr_i(bin_q[AddrW-1:0]), .rdata_o(ph_rd)
  );

  // phase increment: f*pitch, then times hop in two 16-bit halves
  logic signed [41:0] fp_q;
  logic [51:0]        acc_q;
  logic               mhi_q;
  logic [15:0]        hop_part;
  logic signed [58:0] pp;
  assign hop_part = mhi_q ? hop_q[31:16] : hop_q[15:0];
  assign pp       = fp_q * $signed({1'b0, hop_part});
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) fp_q <= freq_q * $signed({1'b0, pitch_q});
    if (cmd_i.div_start) mhi_q <= 1'b0;
    else if (cmd_i.ld_calc) mhi_q <= 1'b1;
    // low half with the rounding constant, then add the high half
    if (cmd_i.ld_calc) begin
      if (!mhi_q) acc_q <= pp[51:0] + 52'd524288;
      else acc_q <= acc_q + {pp[35:0], 16'd0};
    end
  end
  assign ld_we  = cmd_i.ld_write;
  assign ph_new = ph_rd + acc_q[51:20];

  // CORDIC, one iteration a cycle
  logic signed [XW-1:0] x_q, y_q, xs, ys, x0;
  logic signed [ZW-1:0] z_q;
  logic [StepW-1:0]     ccnt_q;
  logic                 live_q;
  logic [53:0]          mprod;
  logic [PhaseW-1:0]    z0;
  logic                 flip;
  assign mprod = mag_rd * InvGainQ30;
  assign flip  = (ph_rd + 32'h40000000) >= 32'h80000000;
  assign z0    = flip ? ph_rd + 32'h80000000 : ph_rd;
  assign x0    = $signed(XW'(mprod[53:22]));
  assign xs    = x_q >>> ccnt_q;
  assign ys    = y_q >>> ccnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_init) begin
      x_q    <= flip ? -x0 : x0;
      y_q    <= '0;
      z_q    <= $signed({z0[31], z0});
      ccnt_q <= '0;
      live_q <= kind_q && bin_ok && src_ok && (mag_rd > floor_q);
    end else if (cmd_i.cordic_step) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - $signed({1'b0, atan_turns(ccnt_q)});
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + $signed({1'b0, atan_turns(ccnt_q)});
      end
      ccnt_q <= ccnt_q + StepW'(1);
    end
  end

  function automatic logic signed [OutW-1:0] fin(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + XW'(128)) >>> 8;
    if (r > $signed(XW'(OutLimit))) return OutW'(OutLimit);
    if (r < -$signed(XW'(OutLimit))) return -$signed(OutW'(OutLimit));
    return r[OutW-1:0];
  endfunction

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_bin_o    <= bin_q;
      out_re_o     <= live_q ? fin(x_q) : '0;
      out_im_o     <= live_q ? fin(y_q) : '0;
      out_mirror_o <= bin_ok && (bin_q != '0) && (bin_q != BinW'(HalfPoints));
    end
  end

  always_comb begin
    sts_o.kind        = kind_q;
    sts_o.bin_ok      = bin_ok;
    sts_o.div_needed  = !bypass && !fzero && bin_ok;
    sts_o.div_last    = (dcnt_q == StepW'(DivW - 1));
    sts_o.cordic_last = (ccnt_q == StepW'(CordicSteps - 1));
    sts_o.out_busy    = out_valid_o && !out_ready_i;
    sts_o.mul_last    = mhi_q;
    sts_o.clearing    = clr_busy_q;
  end

`ifndef NO_ASSERTIONS
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && !live_q |=> out_re_o == '0 && out_im_o == '0)
    else $error("silent bin not zero");
  a_mirror_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_mirror_o |-> out_bin_o != '0) else $error("bad mirror");
`endif
endmodule
`default_nettype wire
